// ===== design/kwm_pkg.sv =====
`default_nettype none

package kwm_pkg;

   // default geometry
   localparam int LISTS_DEFAULT = 8;
   localparam int DEPTH_DEFAULT = 64;

   // field widths
   localparam int OPCODE_W     = 2;
   localparam int LIST_INDEX_W = 3;
   localparam int VALUE_W      = 32;
   localparam int STATUS_W     = 2;
   localparam int REQ_TDATA_W  = 40;
   localparam int RSP_TDATA_W  = 40;

   // command codes
   localparam logic [OPCODE_W-1:0] OP_PUSH  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_POP   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   // control between sequencer and list descriptor store
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear;
   } kwm_meta_ctl_type;

endpackage

`default_nettype wire

// ===== design/k_way_sorted_list_merge.sv =====
`default_nettype none

// K-way merge of sorted lists. Each list is a ring FIFO of DEPTH signed
// 32-bit entries in one shared element memory (LISTS*DEPTH words); a small
// descriptor memory holds each list's head pointer and fill count. Push
// appends to one list (status full if the list holds DEPTH entries or the
// index is not below LISTS), pop removes and returns the smallest head, the
// highest-numbered list winning ties (status empty if nothing is stored),
// clear empties every list at once through the descriptor valid bits.
// Exactly one result transfer follows each request transfer. A push steps
// through descriptor read, element and descriptor write and result hand-off;
// clear and unused opcodes go straight to the hand-off; a pop scans the
// lists, reading one descriptor per cycle, and feeds a two-stage
// descriptor-read / element-read pipeline into a single signed comparator,
// then writes back the winner's descriptor and hands off the result. One
// request is in work at a time; the next request transfer can be taken once
// the result has entered the output register, while that result still waits
// there. A result held by output backpressure holds the sequencer. No
// clearing pass is needed after reset.
module k_way_sorted_list_merge #(
   parameter int LISTS = kwm_pkg::LISTS_DEFAULT,
   parameter int DEPTH = kwm_pkg::DEPTH_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request: [1:0] opcode, [4:2] list_index, [36:5] value, [39:37] zero
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [kwm_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // result: [31:0] out_value, [33:32] status, [39:34] zero
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [kwm_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import kwm_pkg::*;

   localparam int LIST_W = $clog2(LISTS);
   localparam int HEAD_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = $clog2(LISTS * DEPTH);
   localparam int SCAN_W = $clog2(LISTS + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_PUSH_RD  = 3'd1;
   localparam logic [2:0] S_PUSH_WR  = 3'd2;
   localparam logic [2:0] S_POP_SCAN = 3'd3;
   localparam logic [2:0] S_POP_UPD  = 3'd4;
   localparam logic [2:0] S_DONE     = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic                    req_xfer;

   // latched command
   logic [LIST_INDEX_W-1:0] cmd_list_ff, cmd_list_in;
   logic [VALUE_W-1:0]      cmd_value_ff, cmd_value_in;

   // pop scan pipeline
   logic [SCAN_W-1:0]       iss_ff, iss_in;
   logic                    s1_vld_ff, s1_vld_in;
   logic [LIST_W-1:0]       s1_idx_ff, s1_idx_in;
   logic                    s2_vld_ff, s2_vld_in;
   logic [LIST_W-1:0]       s2_idx_ff, s2_idx_in;
   logic [HEAD_W-1:0]       s2_head_ff, s2_head_in;
   logic [CNT_W-1:0]        s2_cnt_ff, s2_cnt_in;

   // running minimum
   logic                    best_found_ff, best_found_in;
   logic [LIST_W-1:0]       best_idx_ff, best_idx_in;
   logic [HEAD_W-1:0]       best_head_ff, best_head_in;
   logic [CNT_W-1:0]        best_cnt_ff, best_cnt_in;
   logic [VALUE_W-1:0]      best_val_ff, best_val_in;

   // finished result and output register
   logic [VALUE_W-1:0]      res_value_ff, res_value_in;
   logic [STATUS_W-1:0]     res_status_ff, res_status_in;
   logic                    rsp_vld_ff, rsp_vld_in;
   logic [VALUE_W-1:0]      rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;

   // descriptor store
   kwm_meta_ctl_type        meta_ctl;
   logic [LIST_W-1:0]       meta_rd_addr, meta_wr_addr;
   logic [HEAD_W-1:0]       meta_wr_head, meta_rd_head;
   logic [CNT_W-1:0]        meta_wr_cnt, meta_rd_cnt;

   // element memory
   logic [VALUE_W-1:0]      elem_mem [LISTS * DEPTH];
   logic [VALUE_W-1:0]      elem_rd_ff;
   logic                    elem_we, elem_re;
   logic [ADDR_W-1:0]       elem_waddr, elem_raddr;

   // push address arithmetic
   logic                    push_list_ok, push_not_full;
   logic [LIST_W-1:0]       push_list;
   logic [CNT_W:0]          slot_sum;
   logic [HEAD_W-1:0]       push_slot;
   logic [HEAD_W:0]         head_inc;
   logic                    s2_better;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   assign push_list     = LIST_W'(cmd_list_ff);
   assign push_list_ok  = (32'(cmd_list_ff) < 32'(LISTS));
   assign push_not_full = (meta_rd_cnt < CNT_W'(DEPTH));
   assign slot_sum      = (CNT_W+1)'(meta_rd_head) + (CNT_W+1)'(meta_rd_cnt);
   // wrap of head + count: sum stays below 2*DEPTH
   assign push_slot     = (slot_sum >= (CNT_W+1)'(DEPTH))
                          ? HEAD_W'(slot_sum - (CNT_W+1)'(DEPTH))
                          : HEAD_W'(slot_sum);
   assign head_inc      = (HEAD_W+1)'(best_head_ff) + (HEAD_W+1)'(1);

   // later list wins a tie, hence <=
   assign s2_better = !best_found_ff ||
                      ($signed(elem_rd_ff) <= $signed(best_val_ff));

   always_comb begin
      state_in      = state_ff;
      cmd_list_in   = cmd_list_ff;
      cmd_value_in  = cmd_value_ff;
      iss_in        = iss_ff;
      s1_vld_in     = 1'b0;
      s1_idx_in     = s1_idx_ff;
      s2_vld_in     = 1'b0;
      s2_idx_in     = s2_idx_ff;
      s2_head_in    = s2_head_ff;
      s2_cnt_in     = s2_cnt_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_head_in  = best_head_ff;
      best_cnt_in   = best_cnt_ff;
      best_val_in   = best_val_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_vld_in    = rsp_vld_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      meta_ctl      = '0;
      meta_rd_addr  = iss_ff[LIST_W-1:0];
      meta_wr_addr  = push_list;
      meta_wr_head  = meta_rd_head;
      meta_wr_cnt   = meta_rd_cnt + CNT_W'(1);

      elem_we       = 1'b0;
      elem_waddr    = ADDR_W'(push_list) * ADDR_W'(DEPTH) + ADDR_W'(push_slot);
      elem_re       = s1_vld_ff;
      elem_raddr    = ADDR_W'(s1_idx_ff) * ADDR_W'(DEPTH) + ADDR_W'(meta_rd_head);

      // output register drains independently of the sequencer
      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               cmd_list_in   = req_tdata[4:2];
               cmd_value_in  = req_tdata[36:5];
               res_value_in  = '0;
               res_status_in = STATUS_OK;
               iss_in        = '0;
               best_found_in = 1'b0;
               case (req_tdata[1:0])
                  OP_PUSH: begin
                     state_in = S_PUSH_RD;
                  end
                  OP_POP: begin
                     state_in = S_POP_SCAN;
                  end
                  OP_CLEAR: begin
                     meta_ctl.clear = 1'b1;
                     state_in       = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_PUSH_RD: begin
            meta_ctl.rd_en = 1'b1;
            meta_rd_addr   = push_list;
            state_in       = S_PUSH_WR;
         end

         S_PUSH_WR: begin
            if (push_list_ok && push_not_full) begin
               elem_we        = 1'b1;
               meta_ctl.wr_en = 1'b1;
            end else begin
               res_status_in = STATUS_FULL;
            end
            state_in = S_DONE;
         end

         S_POP_SCAN: begin
            // stage 0: descriptor read
            if (iss_ff < SCAN_W'(LISTS)) begin
               meta_ctl.rd_en = 1'b1;
               s1_vld_in      = 1'b1;
               s1_idx_in      = iss_ff[LIST_W-1:0];
               iss_in         = iss_ff + SCAN_W'(1);
            end
            // stage 1: element read for a non-empty list
            if (s1_vld_ff && meta_rd_cnt != '0) begin
               s2_vld_in  = 1'b1;
               s2_idx_in  = s1_idx_ff;
               s2_head_in = meta_rd_head;
               s2_cnt_in  = meta_rd_cnt;
            end
            // stage 2: compare against running minimum
            if (s2_vld_ff && s2_better) begin
               best_found_in = 1'b1;
               best_idx_in   = s2_idx_ff;
               best_head_in  = s2_head_ff;
               best_cnt_in   = s2_cnt_ff;
               best_val_in   = elem_rd_ff;
            end
            if (iss_ff == SCAN_W'(LISTS) && !s1_vld_ff && !s2_vld_ff) begin
               state_in = S_POP_UPD;
            end
         end

         S_POP_UPD: begin
            if (best_found_ff) begin
               meta_ctl.wr_en = 1'b1;
               meta_wr_addr   = best_idx_ff;
               meta_wr_head   = (head_inc == (HEAD_W+1)'(DEPTH))
                                ? '0 : HEAD_W'(head_inc);
               meta_wr_cnt    = best_cnt_ff - CNT_W'(1);
               res_value_in   = best_val_ff;
            end else begin
               res_status_in = STATUS_EMPTY;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in    = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         iss_ff        <= '0;
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         best_found_ff <= 1'b0;
         rsp_vld_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         iss_ff        <= iss_in;
         s1_vld_ff     <= s1_vld_in;
         s2_vld_ff     <= s2_vld_in;
         best_found_ff <= best_found_in;
         rsp_vld_ff    <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_list_ff   <= cmd_list_in;
      cmd_value_ff  <= cmd_value_in;
      s1_idx_ff     <= s1_idx_in;
      s2_idx_ff     <= s2_idx_in;
      s2_head_ff    <= s2_head_in;
      s2_cnt_ff     <= s2_cnt_in;
      best_idx_ff   <= best_idx_in;
      best_head_ff  <= best_head_in;
      best_cnt_ff   <= best_cnt_in;
      best_val_ff   <= best_val_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // element memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (elem_we) begin
         elem_mem[elem_waddr] <= cmd_value_ff;
      end
      if (elem_re) begin
         elem_rd_ff <= elem_mem[elem_raddr];
      end
   end

   kwm_meta #(
      .LISTS  (LISTS),
      .HEAD_W (HEAD_W),
      .CNT_W  (CNT_W)
   ) u_meta (
      .clock   (clock),
      .reset   (reset),
      .ctl     (meta_ctl),
      .rd_addr (meta_rd_addr),
      .wr_addr (meta_wr_addr),
      .wr_head (meta_wr_head),
      .wr_cnt  (meta_wr_cnt),
      .rd_head (meta_rd_head),
      .rd_cnt  (meta_rd_cnt)
   );

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - VALUE_W - STATUS_W)'(0), rsp_status_ff, rsp_value_ff};

   // failed commands always return a zero value
   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_status_ff != STATUS_OK) |-> rsp_value_ff == '0)
      else $error("nonzero value with failing status");

   // scan pipeline fully drained before the winner is written back
   a_scan_drained: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP_UPD) |-> (!s1_vld_ff && !s2_vld_ff))
      else $error("pop write-back with scan still in flight");

   // a list never records more than DEPTH entries
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      meta_ctl.wr_en |-> meta_wr_cnt <= CNT_W'(DEPTH))
      else $error("fill count beyond depth");

   // finished result waits while the output register is still held
   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_vld_ff && !rsp_tready) |=> state_ff == S_DONE)
      else $error("result left while output register busy");

endmodule

`default_nettype wire

// ===== design/kwm_meta.sv =====
`default_nettype none

// Per-list descriptor store: head pointer and fill count for each list.
// One write and one read port, registered read. Valid bits make an
// unwritten or cleared row read as zero.
module kwm_meta #(
   parameter int LISTS  = kwm_pkg::LISTS_DEFAULT,
   parameter int HEAD_W = 6,
   parameter int CNT_W  = 7
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire kwm_pkg::kwm_meta_ctl_type      ctl,
   input  wire logic [$clog2(LISTS)-1:0]       rd_addr,
   input  wire logic [$clog2(LISTS)-1:0]       wr_addr,
   input  wire logic [HEAD_W-1:0]              wr_head,
   input  wire logic [CNT_W-1:0]               wr_cnt,
   output logic      [HEAD_W-1:0]              rd_head,
   output logic      [CNT_W-1:0]               rd_cnt
);
   import kwm_pkg::*;

   localparam int ROW_W = HEAD_W + CNT_W;

   logic [ROW_W-1:0] mem [LISTS];
   logic [ROW_W-1:0] rd_data_ff;
   logic             rd_vld_ff;
   logic             rd_vld_in;
   logic [LISTS-1:0] valid_ff;
   logic [LISTS-1:0] valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   assign rd_vld_in = ctl.rd_en ? valid_ff[rd_addr] : rd_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= {wr_head, wr_cnt};
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_head = rd_vld_ff ? rd_data_ff[ROW_W-1:CNT_W] : '0;
   assign rd_cnt  = rd_vld_ff ? rd_data_ff[CNT_W-1:0]     : '0;

   // sequencer never reads and writes one row in the same cycle
   a_no_rw_same_row: assert property (@(posedge clock) disable iff (reset)
      !(ctl.rd_en && ctl.wr_en && rd_addr == wr_addr))
      else $error("descriptor read and write collide");

   a_no_clear_with_write: assert property (@(posedge clock) disable iff (reset)
      !(ctl.clear && ctl.wr_en))
      else $error("descriptor clear overlaps a write");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      ctl.clear |=> valid_ff == '0)
      else $error("descriptor rows still valid after clear");

endmodule

`default_nettype wire
